/* src/lcd_scanline_timing_control_defines.svh */
// assertion macros used by the lcd scanline timing checker
`ifndef LCD_SCANLINE_TIMING_CONTROL_DEFINES_SVH
`define LCD_SCANLINE_TIMING_CONTROL_DEFINES_SVH

// same-cycle implication, held off during reset
`define LST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lst check failed");

// next-cycle implication, held off during reset
`define LST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lst check failed");

`endif

/* src/lst_pkg.sv */
// types and constants of the lcd scanline timing block
`default_nettype none
package lst_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        LM_HBLANK = 2'd0,
        LM_VBLANK = 2'd1,
        LM_OAM    = 2'd2,
        LM_DRAW   = 2'd3
    } t_lcd_mode;

    localparam logic [8:0] DOTS_PER_LINE = 9'd456;
    localparam logic [8:0] OAM_END_DOT   = 9'd80;
    localparam logic [8:0] DRAW_END_DOT  = 9'd252;
    localparam logic [8:0] DOTS_PER_TICK = 9'd4;
    localparam logic [7:0] VISIBLE_LINES = 8'd144;
    localparam logic [7:0] LAST_LINE     = 8'd153;
    localparam logic [7:0] UNMAPPED_READ = 8'hff;

    localparam logic [15:0] ADDR_LCDC = 16'hff40;
    localparam logic [15:0] ADDR_STAT = 16'hff41;
    localparam logic [15:0] ADDR_SCY  = 16'hff42;
    localparam logic [15:0] ADDR_SCX  = 16'hff43;
    localparam logic [15:0] ADDR_LY   = 16'hff44;
    localparam logic [15:0] ADDR_LYC  = 16'hff45;
    localparam logic [15:0] ADDR_PAL0 = 16'hff47;
    localparam logic [15:0] ADDR_PAL1 = 16'hff48;
    localparam logic [15:0] ADDR_PAL2 = 16'hff49;
    localparam logic [15:0] ADDR_WY   = 16'hff4a;
    localparam logic [15:0] ADDR_WX   = 16'hff4b;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       stat_irq;
        logic       vblank_irq;
        logic       render_line;
        logic       frame_done;
        logic [1:0] lcd_mode;
        logic [7:0] line_number;
        logic       vram_open;
        logic       oam_open;
    } t_result;

endpackage
`default_nettype wire

/* src/lst_if.sv */
// request and result channel interfaces
`default_nettype none
interface lst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output mode, output address, output write_data,
                    input ready);
    modport sink (input valid, input mode, input address, input write_data,
                  output ready);
endinterface

interface lst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       stat_irq;
    logic       vblank_irq;
    logic       render_line;
    logic       frame_done;
    logic [1:0] lcd_mode;
    logic [7:0] line_number;
    logic       vram_open;
    logic       oam_open;

    modport source (output valid, output read_data, output stat_irq, output vblank_irq,
                    output render_line, output frame_done, output lcd_mode,
                    output line_number, output vram_open, output oam_open,
                    input ready);
    modport sink (input valid, input read_data, input stat_irq, input vblank_irq,
                  input render_line, input frame_done, input lcd_mode,
                  input line_number, input vram_open, input oam_open,
                  output ready);
endinterface
`default_nettype wire

/* src/lcd_scanline_timing_control.sv */
// lcd scanline timing: one request per clock while results are being taken
// Each request (a tick of four dots, a register read or a register write) is taken into an
// input register, goes through the register and counter update once the result register
// is free and lands in the result register. A new request is taken every cycle as long as
// results are being taken; a stalled result holds one request in the input register and no
// more. The whole timing state (dot and line counters, mode, register file) is updated once
// per request in that middle step, which sets the rate of one request per clock while
// results are being taken.
`default_nettype none
module lcd_scanline_timing_control
    import lst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lst_in_if.sink    i_req,
    lst_out_if.source o_rsp
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    logic    advance;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.mode       <= i_req.mode;
            r_in.address    <= i_req.address;
            r_in.write_data <= i_req.write_data;
        end
    end

    lst_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out.read_data;
    assign o_rsp.stat_irq    = r_out.stat_irq;
    assign o_rsp.vblank_irq  = r_out.vblank_irq;
    assign o_rsp.render_line = r_out.render_line;
    assign o_rsp.frame_done  = r_out.frame_done;
    assign o_rsp.lcd_mode    = r_out.lcd_mode;
    assign o_rsp.line_number = r_out.line_number;
    assign o_rsp.vram_open   = r_out.vram_open;
    assign o_rsp.oam_open    = r_out.oam_open;

endmodule
`default_nettype wire

/* src/lst_step.sv */
// lcd registers, dot and line counters and the per-request update logic
`default_nettype none
module lst_step
    import lst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    output t_result o_result
);

    logic [7:0]  r_lcdc, n_lcdc;
    logic [3:0]  r_stat_en, n_stat_en;   // status bits 6..3
    logic [7:0]  r_scy, n_scy;
    logic [7:0]  r_scx, n_scx;
    logic [7:0]  r_lyc, n_lyc;
    logic [7:0]  r_wy, n_wy;
    logic [7:0]  r_wx, n_wx;
    logic [7:0]  r_pal [3];
    logic [7:0]  n_pal [3];
    logic [7:0]  r_line, n_line;
    logic [8:0]  r_dot, n_dot;
    t_lcd_mode   r_mode, n_mode;
    logic        r_quirk, n_quirk;
    logic        r_prev, n_prev;

    logic [8:0]  dot_inc;
    logic        cmp_eval;
    logic        match;
    logic [7:0]  rd;
    logic        stat, vbl, render, frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc    <= '0;
            r_stat_en <= '0;
            r_scy     <= '0;
            r_scx     <= '0;
            r_lyc     <= '0;
            r_wy      <= '0;
            r_wx      <= '0;
            r_pal[0]  <= '0;
            r_pal[1]  <= '0;
            r_pal[2]  <= '0;
            r_line    <= '0;
            r_dot     <= '0;
            r_mode    <= LM_HBLANK;
            r_quirk   <= 1'b0;
            r_prev    <= 1'b0;
        end else if (i_en) begin
            r_lcdc    <= n_lcdc;
            r_stat_en <= n_stat_en;
            r_scy     <= n_scy;
            r_scx     <= n_scx;
            r_lyc     <= n_lyc;
            r_wy      <= n_wy;
            r_wx      <= n_wx;
            r_pal[0]  <= n_pal[0];
            r_pal[1]  <= n_pal[1];
            r_pal[2]  <= n_pal[2];
            r_line    <= n_line;
            r_dot     <= n_dot;
            r_mode    <= n_mode;
            r_quirk   <= n_quirk;
            r_prev    <= n_prev;
        end
    end

    assign dot_inc = r_dot + DOTS_PER_TICK;

    always_comb begin
        n_lcdc    = r_lcdc;
        n_stat_en = r_stat_en;
        n_scy     = r_scy;
        n_scx     = r_scx;
        n_lyc     = r_lyc;
        n_wy      = r_wy;
        n_wx      = r_wx;
        n_pal[0]  = r_pal[0];
        n_pal[1]  = r_pal[1];
        n_pal[2]  = r_pal[2];
        n_line    = r_line;
        n_dot     = r_dot;
        n_mode    = r_mode;
        n_quirk   = r_quirk;
        n_prev    = r_prev;
        cmp_eval  = 1'b0;
        match     = 1'b0;
        rd        = '0;
        stat      = 1'b0;
        vbl       = 1'b0;
        render    = 1'b0;
        frame     = 1'b0;

        case (i_item.mode)
            OP_READ: begin
                case (i_item.address)
                    ADDR_LCDC: rd = r_lcdc;
                    ADDR_STAT: rd = {1'b1, r_stat_en, (r_line == r_lyc), r_mode};
                    ADDR_SCY:  rd = r_scy;
                    ADDR_SCX:  rd = r_scx;
                    ADDR_LY:   rd = r_line;
                    ADDR_LYC:  rd = r_lyc;
                    ADDR_PAL0: rd = r_pal[0];
                    ADDR_PAL1: rd = r_pal[1];
                    ADDR_PAL2: rd = r_pal[2];
                    ADDR_WY:   rd = r_wy;
                    ADDR_WX:   rd = r_wx;
                    default:   rd = UNMAPPED_READ;
                endcase
            end
            OP_WRITE: begin
                case (i_item.address)
                    ADDR_LCDC: n_lcdc    = i_item.write_data;
                    ADDR_STAT: n_stat_en = i_item.write_data[6:3];
                    ADDR_SCY:  n_scy     = i_item.write_data;
                    ADDR_SCX:  n_scx     = i_item.write_data;
                    ADDR_LYC: begin
                        n_lyc    = i_item.write_data;
                        cmp_eval = 1'b1;
                    end
                    ADDR_PAL0: n_pal[0]  = i_item.write_data;
                    ADDR_PAL1: n_pal[1]  = i_item.write_data;
                    ADDR_PAL2: n_pal[2]  = i_item.write_data;
                    ADDR_WY:   n_wy      = i_item.write_data;
                    ADDR_WX:   n_wx      = i_item.write_data;
                    default:   ;
                endcase
            end
            OP_TICK: begin
                if (!r_lcdc[7]) begin
                    // display off: park at the top of vblank
                    n_dot   = '0;
                    n_line  = VISIBLE_LINES;
                    n_mode  = LM_VBLANK;
                    n_quirk = 1'b1;
                end else begin
                    n_dot = dot_inc;
                    if (r_quirk) begin
                        // first line after enable or after the last line only counts dots
                        if (dot_inc >= DOTS_PER_LINE) begin
                            n_dot   = '0;
                            n_mode  = LM_OAM;
                            n_quirk = 1'b0;
                            stat    = r_stat_en[2];
                        end
                    end else if (r_line < VISIBLE_LINES) begin
                        if (dot_inc >= DOTS_PER_LINE) begin
                            if (r_line < VISIBLE_LINES - 8'd1) begin
                                n_mode = LM_OAM;
                                stat   = r_stat_en[2];
                            end else begin
                                n_mode = LM_VBLANK;
                                stat   = r_stat_en[1];
                                vbl    = 1'b1;
                                frame  = 1'b1;
                            end
                            n_line   = r_line + 8'd1;
                            n_dot    = '0;
                            cmp_eval = 1'b1;
                        end else if (dot_inc == OAM_END_DOT) begin
                            n_mode = LM_DRAW;
                        end else if (dot_inc == DRAW_END_DOT) begin
                            n_mode = LM_HBLANK;
                            stat   = r_stat_en[0];
                            render = 1'b1;
                        end
                    end else if (r_line < LAST_LINE) begin
                        if (dot_inc >= DOTS_PER_LINE) begin
                            n_line   = r_line + 8'd1;
                            n_dot    = '0;
                            cmp_eval = 1'b1;
                        end
                    end else begin
                        // last line is a single tick long
                        n_quirk  = 1'b1;
                        n_line   = '0;
                        cmp_eval = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // line compare fires on a rising match only
        if (cmp_eval) begin
            match  = (n_line == n_lyc);
            n_prev = match;
            if (match && !r_prev && r_stat_en[3]) begin
                stat = 1'b1;
            end
        end
    end

    always_comb begin
        o_result.read_data   = rd;
        o_result.stat_irq    = stat;
        o_result.vblank_irq  = vbl;
        o_result.render_line = render;
        o_result.frame_done  = frame;
        o_result.lcd_mode    = n_mode;
        o_result.line_number = n_line;
        o_result.vram_open   = (n_mode != LM_DRAW);
        o_result.oam_open    = !n_mode[1];
    end

endmodule
`default_nettype wire

/* src/lst_checker.sv */
// port-level checks of the lcd scanline timing block and their binding
`default_nettype none
`include "lcd_scanline_timing_control_defines.svh"
module lst_checker
    import lst_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic       i_vblank_irq,
    input logic       i_render_line,
    input logic       i_frame_done,
    input logic [1:0] i_lcd_mode,
    input logic [7:0] i_line_number,
    input logic       i_vram_open,
    input logic       i_oam_open
);

    // access windows follow the reported mode
    `LST_ASSERT_NOW(a_windows, i_clk, i_rst_n, i_out_valid, (i_vram_open == (i_lcd_mode != LM_DRAW)) && (i_oam_open == !i_lcd_mode[1]))

    // entering vblank only happens at the end of the last visible line
    `LST_ASSERT_NOW(a_vblank_entry, i_clk, i_rst_n, i_out_valid && i_vblank_irq, i_frame_done && (i_lcd_mode == LM_VBLANK) && (i_line_number == VISIBLE_LINES))

    // a line render request comes with the switch into hblank on a visible line
    `LST_ASSERT_NOW(a_render_hblank, i_clk, i_rst_n, i_out_valid && i_render_line, (i_lcd_mode == LM_HBLANK) && (i_line_number < VISIBLE_LINES) && !i_frame_done)

    // line counter never leaves the frame
    `LST_ASSERT_NOW(a_line_range, i_clk, i_rst_n, i_out_valid, i_line_number <= LAST_LINE)

    // a stalled result holds
    `LST_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_read_data) && $stable(i_line_number) && $stable(i_lcd_mode))

endmodule

bind lcd_scanline_timing_control lst_checker u_lst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_read_data   (o_rsp.read_data),
    .i_vblank_irq  (o_rsp.vblank_irq),
    .i_render_line (o_rsp.render_line),
    .i_frame_done  (o_rsp.frame_done),
    .i_lcd_mode    (o_rsp.lcd_mode),
    .i_line_number (o_rsp.line_number),
    .i_vram_open   (o_rsp.vram_open),
    .i_oam_open    (o_rsp.oam_open)
);
`default_nettype wire
